FILE: rtl/delimited_frame_extractor_defines.svh
// Assertion macros used by the checker file of the frame extractor.
`ifndef DELIMITED_FRAME_EXTRACTOR_DEFINES_SVH
`define DELIMITED_FRAME_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define DFE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define DFE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_pkg: shared definitions of the delimited frame extractor
// Register indexes, field widths, defaults and small helper functions.
// ----------------------------------------------------------------------------
package dfe_pkg;

  localparam int BUF_DEPTH_DEF   = 64;
  localparam int MAX_PATTERN_DEF = 7;
  localparam int MIN_FRAME_DEF   = 10;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 7;
  localparam int PROG_W   = 3;
  localparam int PAT_W    = 59;
  localparam int CFG_AW   = 3;
  localparam int NUM_PAT  = 4;

  // Output tdata layout: out_byte, then frame_length, padded to 16 bits.
  localparam int OUT_TDATA_W = 16;
  localparam int LEN_LSB     = BYTE_W;
  localparam int LEN_MSB     = BYTE_W + CNT_W - 1;

  localparam logic [CFG_AW-1:0] CFG_HEAD_START = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_HEAD_END   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_TAIL_START = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_TAIL_END   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MAX_LEN    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_STRIP_HEAD = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_STRIP_TAIL = 3'd6;

  localparam logic [CNT_W-1:0] MAX_LEN_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Byte k of a packed delimiter pattern, first byte in the low bits.
  function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] r,
                                                 input logic [PROG_W-1:0] k);
    logic [PAT_W-1:0] sh;
    sh = r >> {k, 3'b000};
    return sh[BYTE_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: rtl/dfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_ram: generic single-write, single-read RAM
// Synchronous write, registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module dfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/delimited_frame_extractor.sv
`timescale 1ns / 1ps
// A byte is matched in the cycle it is accepted; one byte per cycle while idle.
// The closing byte of a completed frame sets the state to emit; its bytes then
// leave one per cycle unless m_tready stalls, via the single registered read
// port of the frame store; input waits until the last byte has been read out.
// Reset clears state, counters, pattern progress and configuration, not the store.
// ----------------------------------------------------------------------------
// delimited_frame_extractor
// Byte-stream deframer: buffers bytes, tracks four delimiter patterns and
// streams out each completed frame, optionally without header and trailer.
// ----------------------------------------------------------------------------
module delimited_frame_extractor #(
  parameter int BUF_DEPTH   = dfe_pkg::BUF_DEPTH_DEF,
  parameter int MAX_PATTERN = dfe_pkg::MAX_PATTERN_DEF,
  parameter int MIN_FRAME   = dfe_pkg::MIN_FRAME_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dfe_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] in_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dfe_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [14:8] frame_length
  output logic                             m_tlast,   // frame_last
  input  logic                             cfg_we,
  input  logic [dfe_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [dfe_pkg::PAT_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = dfe_pkg::CNT_W;
  localparam int PW = dfe_pkg::PROG_W;

  // Configuration registers.
  logic [dfe_pkg::NUM_PAT-1:0][dfe_pkg::PAT_W-1:0] pat;
  logic [CW-1:0] max_len;
  logic          strip_head;
  logic          strip_tail;

  // Matching state.
  dfe_pkg::state_t state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] head_cnt, head_next;
  logic [CW-1:0] tail_cnt, tail_next;
  logic [dfe_pkg::NUM_PAT-1:0][PW-1:0] prog, prog_next;

  // Emission state.
  logic [CW-1:0] emit_len, emit_start, emit_idx;
  logic [CW-1:0] go_len, go_start;
  logic          go_emit;
  logic [CW-1:0] len_reg;
  logic          last_reg;

  logic          accept;
  logic          issue;
  logic          wr_en;
  logic [CW-1:0] wr_pos;
  logic [CW-1:0] rd_pos;
  logic [dfe_pkg::BYTE_W-1:0] rd_byte;

  logic [PW-1:0] plen [dfe_pkg::NUM_PAT];
  logic [CW-1:0] limit;

  assign s_tready = (state == dfe_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign issue    = (state == dfe_pkg::ST_EMIT) && (!m_tvalid || m_tready);
  assign rd_pos   = emit_start + emit_idx;

  always_comb begin
    for (int i = 0; i < dfe_pkg::NUM_PAT; i++) begin
      plen[i] = (pat[i][58:56] > PW'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : pat[i][58:56];
    end
    limit = (int'(max_len) > BUF_DEPTH) ? CW'(BUF_DEPTH) : max_len;
  end

  // Next matching state for the byte on s_tdata.
  always_comb begin
    logic [dfe_pkg::BYTE_W-1:0] b;
    logic [CW-1:0] l;
    b          = s_tdata;
    fill_next  = fill;
    head_next  = head_cnt;
    tail_next  = tail_cnt;
    prog_next  = prog;
    wr_en      = 1'b0;
    wr_pos     = fill;
    go_emit    = 1'b0;
    go_len     = '0;
    go_start   = '0;
    l          = '0;

    if (prog_next[0] >= plen[0] && prog_next[1] < plen[1]) begin
      head_next = dfe_pkg::sat_inc(head_next);
    end
    if (prog_next[2] >= plen[2] && prog_next[3] < plen[3]) begin
      tail_next = dfe_pkg::sat_inc(tail_next);
    end

    // A full buffer drops the byte and all matching so far.
    if (fill_next >= limit) begin
      fill_next = '0;
      head_next = '0;
      tail_next = '0;
      prog_next = '0;
    end else begin
      wr_en     = 1'b1;
      fill_next = fill_next + 1'b1;
    end

    if (prog_next[0] < plen[0]) begin
      if (b == dfe_pkg::pat_byte(pat[0], prog_next[0])) begin
        head_next    = dfe_pkg::sat_inc(head_next);
        prog_next[0] = prog_next[0] + 1'b1;
      end else begin
        fill_next    = '0;
        head_next    = '0;
        prog_next[0] = '0;
      end
    end else if (prog_next[1] < plen[1]) begin
      if (b == dfe_pkg::pat_byte(pat[1], prog_next[1])) begin
        prog_next[1] = prog_next[1] + 1'b1;
      end else begin
        prog_next[1] = '0;
      end
    end else if (prog_next[2] < plen[2]) begin
      if (b == dfe_pkg::pat_byte(pat[2], prog_next[2])) begin
        tail_next    = dfe_pkg::sat_inc(tail_next);
        prog_next[2] = prog_next[2] + 1'b1;
      end else begin
        tail_next    = '0;
        prog_next[2] = '0;
      end
    end else if (prog_next[3] < plen[3]) begin
      if (b == dfe_pkg::pat_byte(pat[3], prog_next[3])) begin
        prog_next[3] = prog_next[3] + 1'b1;
      end else begin
        prog_next[3] = '0;
      end
    end

    if (prog_next[0] >= plen[0] && prog_next[1] >= plen[1] &&
        prog_next[2] >= plen[2] && prog_next[3] >= plen[3]) begin
      if (fill_next < CW'(MIN_FRAME)) begin
        // Too short: start over, and let this byte open a new header if it matches.
        fill_next = '0;
        head_next = '0;
        tail_next = '0;
        prog_next = '0;
        if (plen[0] != '0 && b == dfe_pkg::pat_byte(pat[0], '0)) begin
          wr_en        = 1'b1;
          wr_pos       = '0;
          head_next    = CW'(1);
          prog_next[0] = PW'(1);
          fill_next    = CW'(1);
        end
      end else begin
        l = fill_next;
        if (strip_tail) begin
          l = (l > tail_next) ? l - tail_next : '0;
        end
        if (strip_head) begin
          go_start = head_next;
          l = (l > head_next) ? l - head_next : '0;
        end
        go_len    = l;
        go_emit   = (l != '0);
        fill_next = '0;
        head_next = '0;
        tail_next = '0;
        prog_next = '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dfe_pkg::ST_IDLE: begin
        if (accept && go_emit) begin
          state_next = dfe_pkg::ST_EMIT;
        end
      end
      dfe_pkg::ST_EMIT: begin
        if (issue && (emit_idx + 1'b1 == emit_len)) begin
          state_next = dfe_pkg::ST_IDLE;
        end
      end
      default: state_next = dfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat        <= '0;
      max_len    <= dfe_pkg::MAX_LEN_RST;
      strip_head <= 1'b0;
      strip_tail <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dfe_pkg::CFG_HEAD_START: pat[0]     <= cfg_wdata;
        dfe_pkg::CFG_HEAD_END:   pat[1]     <= cfg_wdata;
        dfe_pkg::CFG_TAIL_START: pat[2]     <= cfg_wdata;
        dfe_pkg::CFG_TAIL_END:   pat[3]     <= cfg_wdata;
        dfe_pkg::CFG_MAX_LEN:    max_len    <= cfg_wdata[CW-1:0];
        dfe_pkg::CFG_STRIP_HEAD: strip_head <= cfg_wdata[0];
        dfe_pkg::CFG_STRIP_TAIL: strip_tail <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dfe_pkg::ST_IDLE;
      fill     <= '0;
      head_cnt <= '0;
      tail_cnt <= '0;
      prog     <= '0;
      emit_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill     <= fill_next;
        head_cnt <= head_next;
        tail_cnt <= tail_next;
        prog     <= prog_next;
        emit_idx <= '0;
      end else if (issue) begin
        emit_idx <= emit_idx + 1'b1;
      end
      if (issue) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && go_emit) begin
      emit_len   <= go_len;
      emit_start <= go_start;
    end
    if (issue) begin
      len_reg  <= emit_len;
      last_reg <= (emit_idx + 1'b1 == emit_len);
    end
  end

  dfe_ram #(
    .WIDTH (dfe_pkg::BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (AW'(wr_pos)),
    .wr_data (s_tdata),
    .rd_en   (issue),
    .rd_addr (AW'(rd_pos)),
    .rd_data (rd_byte)
  );

  assign m_tdata = {{(dfe_pkg::OUT_TDATA_W - dfe_pkg::BYTE_W - CW){1'b0}}, len_reg, rd_byte};
  assign m_tlast = last_reg;

endmodule

FILE: rtl/dfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_checker: port-level checks of the delimited frame extractor
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "delimited_frame_extractor_defines.svh"

module dfe_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dfe_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  // A stalled output item stays put.
  `DFE_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

  // Input is held off while a frame is still being read out.
  `DFE_ASSERT_IMP(a_no_input_mid_frame, clk, rst, m_tvalid && !m_tlast, !s_tready, "input taken in the middle of a frame")

  // Every emitted item carries a nonzero frame length.
  `DFE_ASSERT_IMP(a_len_nonzero, clk, rst, m_tvalid, m_tdata[dfe_pkg::LEN_MSB:dfe_pkg::LEN_LSB] != '0, "zero frame length on output")

  // The frame length stays the same across the items of one frame.
  `DFE_ASSERT_NXT(a_len_steady, clk, rst, m_tvalid && m_tready && !m_tlast, m_tdata[dfe_pkg::LEN_MSB:dfe_pkg::LEN_LSB] == $past(m_tdata[dfe_pkg::LEN_MSB:dfe_pkg::LEN_LSB]), "frame length changed within a frame")

endmodule

bind delimited_frame_extractor dfe_checker u_dfe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
